[src/mgpm_pkg.sv]
// ----------------------------------------------------------------------------
// mgpm_pkg
// Shared constants and types for the monotone grid path moves unit.
// ----------------------------------------------------------------------------
package mgpm_pkg;

  localparam int unsigned MAX_ROWS    = 1024;
  localparam int unsigned MAX_COLUMNS = 65536;
  localparam int unsigned VALUE_WIDTH = 32;

  localparam int unsigned ROW_W  = $clog2(MAX_ROWS);
  localparam int unsigned CNT_W  = ROW_W + 1;
  localparam int unsigned COL_W  = 16;
  localparam int unsigned ADDR_W = 3;

  localparam int unsigned COL_LIMIT_INT = (MAX_COLUMNS - 1 < 65535) ? MAX_COLUMNS - 1 : 65535;
  localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(COL_LIMIT_INT);
  localparam logic [CNT_W-1:0] ROWS_MAX  = CNT_W'(MAX_ROWS);
  localparam logic [CNT_W-1:0] ROWS_MIN  = CNT_W'(1);

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_ROWS_IN_USE = 1'b0
  } cfg_reg_e;

  // one stored row of the previous column
  typedef struct packed {
    logic                   reach;
    logic [VALUE_WIDTH-1:0] value;
  } entry_t;

  // walk state between cells
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    entry_t           upper;
    logic             col_has_reach;
    logic             stopped;
    logic [COL_W-1:0] best;
  } walk_state_t;

endpackage

[src/monotone_grid_path_moves_unit.sv]
// ----------------------------------------------------------------------------
// monotone_grid_path_moves_unit
// Longest strictly rising left-to-right walk through a streamed grid.
//
// Cells arrive column by column, top row first, one word per cycle; the
// unit accepts a word every cycle unless held off as below. A walk may
// start at any cell of the first column and steps one column right to the
// row above, level or below, landing on a strictly larger value. On the
// word marked by tlast the unit returns, in the next cycle, the index of the
// rightmost column that still held a reachable cell (the move count). The
// rate is set by the previous-column row store: one write and two reads
// per cycle, with the reads for the next cell issued while the current one
// is taken. A result waits in an output register; input is held off only
// while that register is full and the sink stalls. Program rows_in_use only
// while no grid is in flight; 0 acts as 1 and values above 1024 as 1024.
// ----------------------------------------------------------------------------
module monotone_grid_path_moves_unit
  import mgpm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // cell stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // [31:0] cell_value
  input  logic              s_axis_tlast,   // last_cell
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // [15:0] max_moves
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [CNT_W-1:0]  rows_q;
  logic [CNT_W-1:0]  rows_eff;
  walk_state_t       walk_q;
  walk_state_t       walk_d;
  entry_t            here;
  entry_t            below;
  entry_t            wr_entry;
  logic [COL_W-1:0]  moves;
  logic              accept;
  logic              out_valid_q;
  logic [COL_W-1:0]  out_moves_q;
  logic              cfg_write;
  logic              reg_sel;

  // ---- configuration port ----
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[2] == REG_ROWS_IN_USE);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_MIN;
    end else if (cfg_write && reg_sel) begin
      rows_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(32-CNT_W){1'b0}}, rows_q} : 32'd0;

  // clamp the programmed row count into the supported range
  always_comb begin
    if (rows_q == '0) begin
      rows_eff = ROWS_MIN;
    end else if (rows_q > ROWS_MAX) begin
      rows_eff = ROWS_MAX;
    end else begin
      rows_eff = rows_q;
    end
  end

  // ---- handshake ----
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ---- previous column store, prefetches rows for the next word ----
  mgpm_row_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (accept),
    .wr_row_i   (walk_q.row),
    .wr_entry_i (wr_entry),
    .rd_row_i   (walk_d.row),
    .here_o     (here),
    .below_o    (below)
  );

  // ---- per-cell evaluation ----
  mgpm_cell_eval u_eval (
    .state_i    (walk_q),
    .here_i     (here),
    .below_i    (below),
    .rows_i     (rows_eff),
    .value_i    (s_axis_tdata[VALUE_WIDTH-1:0]),
    .last_i     (s_axis_tlast),
    .state_o    (walk_d),
    .wr_entry_o (wr_entry),
    .moves_o    (moves)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
    end else if (accept) begin
      walk_q <= walk_d;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && s_axis_tlast) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tlast) begin
      out_moves_q <= moves;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_moves_q;

`ifndef SYNTHESIS
  // a result only appears after a last word was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(accept && s_axis_tlast))
    else $error("result without a last word");

  // a last word restarts the walk at row 0, column 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (walk_q.row == '0 && walk_q.col == '0 && !walk_q.stopped))
    else $error("walk not restarted after last word");

  // once the search stopped, the answer is frozen until the grid ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (walk_q.stopped && !(accept && s_axis_tlast)) |=> (walk_q.best == $past(walk_q.best)))
    else $error("answer changed after search stopped");

  // row never leaves the column while the row count is steady
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && $stable(rows_q)) |=> ({1'b0, walk_q.row} < rows_eff))
    else $error("row position past row count");
`endif

endmodule

[src/mgpm_row_store.sv]
// ----------------------------------------------------------------------------
// mgpm_row_store
// Previous-column store: one write and two registered reads per cell, with
// bypass when a read hits the row written in the same cycle.
// ----------------------------------------------------------------------------
module mgpm_row_store
  import mgpm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [ROW_W-1:0] wr_row_i,
  input  entry_t           wr_entry_i,
  input  logic [ROW_W-1:0] rd_row_i,
  output entry_t           here_o,
  output entry_t           below_o
);

  entry_t           mem_q [MAX_ROWS];
  entry_t           rd_a_q;
  entry_t           rd_b_q;
  entry_t           wr_copy_q;
  logic             hit_a_q;
  logic             hit_b_q;
  logic [ROW_W-1:0] rd_row_b;

  assign rd_row_b = rd_row_i + ROW_W'(1);

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_row_i] <= wr_entry_i;
      rd_a_q          <= mem_q[rd_row_i];
      rd_b_q          <= mem_q[rd_row_b];
      wr_copy_q       <= wr_entry_i;
    end
  end

  // read-first array, so flag reads of the row being written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
    end else if (we_i) begin
      hit_a_q <= (rd_row_i == wr_row_i);
      hit_b_q <= (rd_row_b == wr_row_i);
    end
  end

  assign here_o  = hit_a_q ? wr_copy_q : rd_a_q;
  assign below_o = hit_b_q ? wr_copy_q : rd_b_q;

endmodule

[src/mgpm_cell_eval.sv]
// ----------------------------------------------------------------------------
// mgpm_cell_eval
// Reachability of one cell and the next walk state.
// ----------------------------------------------------------------------------
module mgpm_cell_eval
  import mgpm_pkg::*;
(
  input  walk_state_t            state_i,
  input  entry_t                 here_i,
  input  entry_t                 below_i,
  input  logic [CNT_W-1:0]       rows_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   last_i,
  output walk_state_t            state_o,
  output entry_t                 wr_entry_o,
  output logic [COL_W-1:0]       moves_o
);

  logic [CNT_W-1:0] row_p1;
  logic             from_up;
  logic             from_level;
  logic             from_down;
  logic             reach;
  logic             end_col;
  logic             col_reach;
  walk_state_t      nxt;

  always_comb begin
    row_p1     = {1'b0, state_i.row} + CNT_W'(1);
    from_up    = (state_i.row != '0) && state_i.upper.reach
                 && (state_i.upper.value < value_i);
    from_level = here_i.reach && (here_i.value < value_i);
    from_down  = (row_p1 < rows_i) && below_i.reach && (below_i.value < value_i);
    // first column: every cell is a start
    reach      = (state_i.col == '0) || from_up || from_level || from_down;
    end_col    = last_i || (row_p1 >= rows_i);
    col_reach  = state_i.col_has_reach || reach;

    nxt             = state_i;
    nxt.upper.value = here_i.value;
    nxt.upper.reach = here_i.reach;
    if (end_col) begin
      if (!state_i.stopped) begin
        if (col_reach) begin
          nxt.best = state_i.col;
        end else begin
          nxt.stopped = 1'b1;
        end
      end
      nxt.col_has_reach = 1'b0;
      nxt.row           = '0;
      nxt.upper.reach   = 1'b0;
      if (state_i.col < COL_LIMIT) begin
        nxt.col = state_i.col + COL_W'(1);
      end
    end else begin
      nxt.row           = row_p1[ROW_W-1:0];
      nxt.col_has_reach = col_reach;
    end

    moves_o          = nxt.best;
    wr_entry_o.reach = reach;
    wr_entry_o.value = value_i;

    // new grid after the last cell
    state_o = last_i ? '0 : nxt;
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the monotone grid path moves unit. Grid cells go
// in as words on the cell stream under random gaps. A scoreboard model of the
// column walk predicts the move count of every grid, and each result word is
// checked against it. The row count register is reprogrammed between grids
// across its full range, including zero and values above the row store.
// ----------------------------------------------------------------------------
module tb;
  import mgpm_pkg::*;

  localparam int unsigned IDLE_PCT    = 28;     // chance of a gap per side
  localparam int unsigned STALL_LIMIT = 2000;   // cycles with no word moving
  localparam int unsigned SETTLE      = 8;      // quiet cycles after a drain
  localparam int unsigned CLIMB_CELLS = 100;    // one column per cell
  localparam int unsigned TALL_CELLS  = 40;     // cells of the tall grid
  localparam int unsigned PHASES      = 12;

  localparam logic [ADDR_W-1:0] ROWS_ADDR = ADDR_W'({REG_ROWS_IN_USE, 2'b00});

  // how the cell values of a generated grid are chosen
  typedef enum int unsigned {
    FILL_NOISE,   // any 32-bit value
    FILL_RISING,  // steady climb with noise, long walks
    FILL_CREEP,   // slow climb in small steps, many equal neighbours
    FILL_EDGE     // only the extremes of the value range
  } fill_e;

  typedef struct packed {
    logic        last;
    logic [31:0] value;
  } cell_t;

  // --------------------------------------------------------------------------
  // clock, reset and the block under test
  // --------------------------------------------------------------------------
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata  = '0;    // [31:0] cell_value
  logic              s_axis_tlast  = 1'b0;  // last_cell
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;          // [15:0] max_moves
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;

  monotone_grid_path_moves_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // scoreboard model of the column walk
  // --------------------------------------------------------------------------
  bit [31:0]        prior_value [MAX_ROWS];  // previous column, per row
  bit               prior_reach [MAX_ROWS];
  int unsigned      walk_row;
  int unsigned      walk_col;
  bit [31:0]        upper_value;             // prior entry of the row above
  bit               upper_reach;
  bit               col_reached;             // current column has a reachable cell
  bit               frozen;                  // a dead column ended the search
  bit [15:0]        best_so_far;
  bit [CNT_W-1:0]   rows_reg = CNT_W'(1);    // shadow of rows_in_use

  logic [15:0]      moves_due [$];           // predicted move counts, oldest first
  cell_t            cells_pending [$];       // cells waiting for the driver
  cell_t            drive_cell;
  logic [15:0]      moves_want;
  int unsigned      mismatches;
  int unsigned      stall_cycles;
  bit               cell_taken;              // a cell word moved at the last edge
  bit               calm;                    // no gaps on either side

  task automatic clear_walk();
    walk_row    = 0;
    walk_col    = 0;
    upper_value = '0;
    upper_reach = 1'b0;
    col_reached = 1'b0;
    frozen      = 1'b0;
    best_so_far = '0;
  endtask

  // advance the walk by one accepted cell, queue a move count on the last one
  task automatic climb_step(input logic [31:0] value, input logic last);
    int unsigned rows;
    int unsigned r;
    bit          reach;
    bit          col_done;
    rows = rows_reg;
    if (rows == 0) rows = 1;
    if (rows > MAX_ROWS) rows = MAX_ROWS;
    r = walk_row;
    if (r >= MAX_ROWS) r = MAX_ROWS - 1;

    // any first-column cell starts a walk; later cells need a lower neighbour
    if (walk_col == 0) begin
      reach = 1'b1;
    end else begin
      reach = 1'b0;
      if (r > 0 && upper_reach && upper_value < value) reach = 1'b1;
      if (prior_reach[r] && prior_value[r] < value) reach = 1'b1;
      if (r + 1 < rows && prior_reach[r + 1] && prior_value[r + 1] < value) reach = 1'b1;
    end

    // keep the old entry: the next row down still needs it as its upper neighbour
    upper_value    = prior_value[r];
    upper_reach    = prior_reach[r];
    prior_value[r] = value;
    prior_reach[r] = reach;
    if (reach) col_reached = 1'b1;

    col_done = last || (r + 1 >= rows);
    if (col_done) begin
      if (!frozen) begin
        if (col_reached) best_so_far = walk_col[15:0];
        else frozen = 1'b1;
      end
      col_reached = 1'b0;
      walk_row    = 0;
      upper_reach = 1'b0;
      if (walk_col < COL_LIMIT_INT) walk_col++;
    end else begin
      walk_row = r + 1;
    end

    if (last) begin
      moves_due.push_back(best_so_far);
      clear_walk();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // cell driver and result sink, both change at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      // a word still on offer is held until it has moved
      if (cell_taken || !s_axis_tvalid) begin
        if (cells_pending.size() != 0 && (calm || $urandom_range(99, 0) >= IDLE_PCT)) begin
          drive_cell = cells_pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= drive_cell.value;
          s_axis_tlast  <= drive_cell.last;
        end else begin
          // idle: junk on the data lines must be ignored
          s_axis_tvalid <= 1'b0;
          s_axis_tdata  <= $urandom;
          s_axis_tlast  <= $urandom_range(1, 0);
        end
      end
      m_axis_tready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: sample both streams at the rising edge, predict and compare
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cell_taken   <= 1'b0;
      stall_cycles <= 0;
    end else begin
      cell_taken <= s_axis_tvalid && s_axis_tready;
      // predict first so that even a same-cycle result would find its entry
      if (s_axis_tvalid && s_axis_tready) climb_step(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (moves_due.size() == 0) begin
          report_mismatch("result with nothing due", m_axis_tdata, '0);
        end else begin
          moves_want = moves_due.pop_front();
          if (m_axis_tdata !== moves_want) report_mismatch("max_moves", m_axis_tdata, moves_want);
        end
      end
      // watchdog on cycles where no word moves on either stream
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("FAIL monotone_grid_path_moves_unit");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_cell(input logic [31:0] value, input logic last);
    cell_t c;
    c.value = value;
    c.last  = last;
    cells_pending.push_back(c);
  endtask

  function automatic logic [31:0] pick_value(input fill_e fill, input int unsigned col);
    case (fill)
      FILL_NOISE:  return $urandom;
      FILL_RISING: return col * 256 + $urandom_range(300, 0);
      FILL_CREEP:  return col + $urandom_range(3, 0);
      default: begin
        case ($urandom_range(3, 0))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // one grid of whole columns, the last one cut short half of the time
  task automatic queue_grid(input int unsigned rows, input int unsigned cols,
                            input fill_e fill, input int unsigned tail_max);
    int unsigned height;
    for (int unsigned col = 0; col < cols; col++) begin
      height = rows;
      if (col == cols - 1 && $urandom_range(1, 0))
        height = $urandom_range((rows < tail_max) ? rows : tail_max, 1);
      for (int unsigned r = 0; r < height; r++)
        push_cell(pick_value(fill, col), (col == cols - 1) && (r == height - 1));
    end
  endtask

  function automatic fill_e roll_fill();
    int unsigned roll;
    roll = $urandom_range(9, 0);
    if (roll < 2) return FILL_NOISE;
    if (roll < 6) return FILL_RISING;
    if (roll < 9) return FILL_CREEP;
    return FILL_EDGE;
  endfunction

  // wait until every cell has gone in and every result has come out
  task automatic drain(input int unsigned settle);
    @(posedge clk_i);
    #1;
    while (cells_pending.size() != 0 || s_axis_tvalid || moves_due.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    repeat (settle) @(negedge clk_i);
  endtask

  // program rows_in_use, junk in the unused upper bits, then read it back
  task automatic write_rows(input logic [CNT_W-1:0] rows);
    logic [31:0] data;
    data = ($urandom & ~32'(ROWS_MAX * 2 - 1)) | 32'(rows);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ROWS_ADDR;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    rows_reg = data[CNT_W-1:0];
    @(negedge clk_i);
    psel  = 1'b1;
    paddr = ROWS_ADDR;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata[CNT_W-1:0] !== data[CNT_W-1:0])
      report_mismatch("rows_in_use readback", prdata[CNT_W-1:0], data[CNT_W-1:0]);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  int unsigned rows_plan [PHASES] = '{2, 5, 1, 8, 3, 1024, 0, 16, 4, 64, 7, 2};
  int unsigned rows_eff;

  initial begin
    clear_walk();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset row count of one: a single-cell grid, then an unsigned climb
    push_cell(32'd7, 1'b1);
    push_cell(32'h7FFF_FFFF, 1'b0);
    push_cell(32'h8000_0000, 1'b0);
    push_cell(32'hFFFF_FFFF, 1'b1);
    drain(SETTLE);

    // three rows: diagonal moves up and down, a dead column freezes the
    // answer, a later live-looking column must not revive it, partial tail
    write_rows(CNT_W'(3));
    push_cell(32'd5, 1'b0);
    push_cell(32'd0, 1'b0);
    push_cell(32'hFFFF_FFFF, 1'b0);
    push_cell(32'd6, 1'b0);
    push_cell(32'hFFFF_FFFF, 1'b0);
    push_cell(32'd0, 1'b0);
    push_cell(32'd0, 1'b0);
    push_cell(32'd0, 1'b0);
    push_cell(32'd0, 1'b0);
    push_cell(32'd100, 1'b0);
    push_cell(32'd100, 1'b0);
    push_cell(32'd100, 1'b0);
    push_cell(32'd200, 1'b1);
    drain(SETTLE);

    // zero acts as one row; an equal value is not a move
    write_rows(CNT_W'(0));
    push_cell(32'd3, 1'b0);
    push_cell(32'd3, 1'b0);
    push_cell(32'd4, 1'b1);
    drain(SETTLE);

    // above the store size acts as the maximum; grid ends inside column zero
    write_rows(CNT_W'(ROWS_MAX * 2 - 1));
    push_cell(32'd9, 1'b0);
    push_cell(32'd1, 1'b1);
    drain(SETTLE);

    // a long climb on a single row, one column per cell, no gaps
    write_rows(CNT_W'(1));
    calm = 1'b1;
    for (int unsigned i = 0; i < CLIMB_CELLS; i++)
      push_cell(32'(i + 1), i == CLIMB_CELLS - 1);
    drain(SETTLE);
    calm = 1'b0;

    // random grids; every phase ends with the sender held until all results are in
    for (int unsigned p = 0; p < PHASES; p++) begin
      write_rows(CNT_W'(rows_plan[p]));
      rows_eff = (rows_plan[p] == 0) ? 1 :
                 (rows_plan[p] > MAX_ROWS) ? MAX_ROWS : rows_plan[p];
      calm = (p == 3);
      if (rows_eff >= MAX_ROWS) begin
        // tall grid that ends part way down column zero
        for (int unsigned r = 0; r < TALL_CELLS; r++)
          push_cell(pick_value(FILL_CREEP, 0), r == TALL_CELLS - 1);
      end else if (rows_eff >= 64) begin
        repeat (2) queue_grid(rows_eff, 3, roll_fill(), 64);
      end else begin
        repeat (5) queue_grid(rows_eff, $urandom_range(7, 1), roll_fill(), rows_eff);
      end
      drain(SETTLE);
    end
    calm = 1'b0;

    drain(2 * SETTLE);
    if (mismatches == 0 && moves_due.size() == 0) begin
      $display("PASS monotone_grid_path_moves_unit");
    end else begin
      $display("FAIL monotone_grid_path_moves_unit");
    end
    $finish;
  end

endmodule
